>>> src/vpc_pkg.sv
// ----------------------------------------------------------------------------
// vpc_pkg
// Types and constants shared by the pulse packet classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package vpc_pkg;

  localparam int unsigned ThrW       = 15;
  localparam int unsigned CntW       = 16;
  localparam int unsigned PipW       = 8;
  localparam int unsigned NumTallies = 9;
  localparam int unsigned AddrW      = 5;
  localparam int unsigned DataW      = 32;

  localparam logic [CntW-1:0] BreakLimit  = 16'd65000;
  localparam logic [CntW-1:0] BreakRewind = 16'd101;
  localparam logic [CntW-1:0] CntMax      = 16'hFFFF;
  localparam logic [PipW-1:0] PipMax      = 8'hFF;

  // Tally slots, in result order
  localparam int unsigned TallySingle     = 0;
  localparam int unsigned TallyShortStart = 1;
  localparam int unsigned TallyLongStart  = 2;
  localparam int unsigned TallyShortClog  = 3;
  localparam int unsigned TallyLongClog   = 4;
  localparam int unsigned TallyShortOver  = 5;
  localparam int unsigned TallyLongOver   = 6;
  localparam int unsigned TallyUnknown    = 7;
  localparam int unsigned TallyPass       = 8;

  typedef enum logic [1:0] {
    KindSample    = 2'd0,
    KindTestStart = 2'd1,
    KindTick      = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    RegThreshold    = 3'd0,
    RegPacketGap    = 3'd1,
    RegStartShort   = 3'd2,
    RegStartLong    = 3'd3,
    RegBurstShort   = 3'd4,
    RegBurstLong    = 3'd5,
    RegTestTimeout  = 3'd6
  } reg_idx_e;

  localparam logic [ThrW-1:0] ThresholdRst   = 15'd5;
  localparam logic [CntW-1:0] PacketGapRst   = 16'd50;
  localparam logic [CntW-1:0] StartShortRst  = 16'd25;
  localparam logic [CntW-1:0] StartLongRst   = 16'd45;
  localparam logic [CntW-1:0] BurstShortRst  = 16'd3;
  localparam logic [CntW-1:0] BurstLongRst   = 16'd7;
  localparam logic [CntW-1:0] TestTimeoutRst = 16'd100;

  typedef struct packed {
    logic [ThrW-1:0] pulse_threshold;
    logic [CntW-1:0] packet_gap;
    logic [CntW-1:0] start_short_below;
    logic [CntW-1:0] start_long_above;
    logic [CntW-1:0] burst_short_below;
    logic [CntW-1:0] burst_long_above;
    logic [CntW-1:0] test_timeout;
  } cfg_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [ThrW-1:0] sample_count;
  } item_t;

  typedef struct packed {
    logic                             overheat;
    logic                             clog;
    logic                             self_test_fail;
    logic [NumTallies-1:0][CntW-1:0]  tallies;
  } result_t;

endpackage

`default_nettype wire

>>> src/vpc_in_if.sv
// ----------------------------------------------------------------------------
// vpc_in_if
// Input channel: one item per valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface vpc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [14:0] sample_count;

  modport source (output valid, output kind, output sample_count, input ready);
  modport sink   (input valid, input kind, input sample_count, output ready);
endinterface

`default_nettype wire

>>> src/vpc_out_if.sv
// ----------------------------------------------------------------------------
// vpc_out_if
// Result channel: flags and event tallies, one item per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface vpc_out_if;
  logic        valid;
  logic        ready;
  logic        overheat;
  logic        clog;
  logic        self_test_fail;
  logic [15:0] single_window_pulses;
  logic [15:0] short_starts;
  logic [15:0] long_starts;
  logic [15:0] short_clogs;
  logic [15:0] long_clogs;
  logic [15:0] short_overheats;
  logic [15:0] long_overheats;
  logic [15:0] unknown_packets;
  logic [15:0] selftest_passes;

  modport source (
    output valid, input ready,
    output overheat, output clog, output self_test_fail,
    output single_window_pulses, output short_starts, output long_starts,
    output short_clogs, output long_clogs, output short_overheats,
    output long_overheats, output unknown_packets, output selftest_passes
  );
  modport sink (
    input valid, output ready,
    input overheat, input clog, input self_test_fail,
    input single_window_pulses, input short_starts, input long_starts,
    input short_clogs, input long_clogs, input short_overheats,
    input long_overheats, input unknown_packets, input selftest_passes
  );
endinterface

`default_nettype wire

>>> src/vpc_cfg_regs.sv
// ----------------------------------------------------------------------------
// vpc_cfg_regs
// APB register file holding the classifier thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

module vpc_cfg_regs
  import vpc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[AddrW-1:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse_threshold   <= ThresholdRst;
      cfg_q.packet_gap        <= PacketGapRst;
      cfg_q.start_short_below <= StartShortRst;
      cfg_q.start_long_above  <= StartLongRst;
      cfg_q.burst_short_below <= BurstShortRst;
      cfg_q.burst_long_above  <= BurstLongRst;
      cfg_q.test_timeout      <= TestTimeoutRst;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegThreshold:   cfg_q.pulse_threshold   <= pwdata[ThrW-1:0];
        RegPacketGap:   cfg_q.packet_gap        <= pwdata[CntW-1:0];
        RegStartShort:  cfg_q.start_short_below <= pwdata[CntW-1:0];
        RegStartLong:   cfg_q.start_long_above  <= pwdata[CntW-1:0];
        RegBurstShort:  cfg_q.burst_short_below <= pwdata[CntW-1:0];
        RegBurstLong:   cfg_q.burst_long_above  <= pwdata[CntW-1:0];
        RegTestTimeout: cfg_q.test_timeout      <= pwdata[CntW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegThreshold:   prdata = {{(DataW-ThrW){1'b0}}, cfg_q.pulse_threshold};
      RegPacketGap:   prdata = {{(DataW-CntW){1'b0}}, cfg_q.packet_gap};
      RegStartShort:  prdata = {{(DataW-CntW){1'b0}}, cfg_q.start_short_below};
      RegStartLong:   prdata = {{(DataW-CntW){1'b0}}, cfg_q.start_long_above};
      RegBurstShort:  prdata = {{(DataW-CntW){1'b0}}, cfg_q.burst_short_below};
      RegBurstLong:   prdata = {{(DataW-CntW){1'b0}}, cfg_q.burst_long_above};
      RegTestTimeout: prdata = {{(DataW-CntW){1'b0}}, cfg_q.test_timeout};
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> src/vpc_tracker.sv
// ----------------------------------------------------------------------------
// vpc_tracker
// Pulse/break/packet tracking, self-test timer and event tallies.
// ----------------------------------------------------------------------------
`default_nettype none

module vpc_tracker
  import vpc_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  step_i,
  input  item_t      item_i,
  input  cfg_t       cfg_i,
  output result_t    result_o
);

  logic                            pulse_active_q, pulse_active_d;
  logic                            packet_active_q, packet_active_d;
  logic [PipW-1:0]                 pip_q, pip_d;
  logic [CntW-1:0]                 pulse_win_q, pulse_win_d;
  logic [CntW-1:0]                 break_win_q, break_win_d;
  logic                            test_pending_q, test_pending_d;
  logic [CntW-1:0]                 test_elapsed_q, test_elapsed_d;
  logic                            fail_q, fail_d;
  logic                            overheat_q, overheat_d;
  logic                            clog_q, clog_d;
  logic [NumTallies-1:0][CntW-1:0] tally_q;
  logic [NumTallies-1:0]           bump;

  logic [CntW-1:0] break_inc;
  logic [CntW-1:0] elapsed_inc;
  logic            burst_short;
  logic            burst_long;

  assign break_inc   = (pulse_active_q ? '0 : break_win_q) + 1'b1;
  assign elapsed_inc = (test_elapsed_q == CntMax) ? test_elapsed_q
                                                  : test_elapsed_q + 1'b1;
  assign burst_short = pulse_win_q < cfg_i.burst_short_below;
  assign burst_long  = !burst_short && (pulse_win_q > cfg_i.burst_long_above);

  always_comb begin
    pulse_active_d  = pulse_active_q;
    packet_active_d = packet_active_q;
    pip_d           = pip_q;
    pulse_win_d     = pulse_win_q;
    break_win_d     = break_win_q;
    test_pending_d  = test_pending_q;
    test_elapsed_d  = test_elapsed_q;
    fail_d          = fail_q;
    overheat_d      = overheat_q;
    clog_d          = clog_q;
    bump            = '0;

    unique case (item_i.kind)
      KindSample: begin
        if (item_i.sample_count > cfg_i.pulse_threshold) begin
          if (!pulse_active_q) begin
            // open a packet or add a pulse to it
            if (!packet_active_q) begin
              packet_active_d = 1'b1;
              pip_d           = 8'd1;
            end else if (pip_q != PipMax) begin
              pip_d = pip_q + 1'b1;
            end
            pulse_active_d = 1'b1;
            pulse_win_d    = 16'd1;
          end else if (pulse_win_q != CntMax) begin
            pulse_win_d = pulse_win_q + 1'b1;
          end
        end else begin
          if (pulse_active_q && (pulse_win_q == 16'd1)) begin
            bump[TallySingle] = 1'b1;
          end
          pulse_active_d = 1'b0;
          // close the packet once the break outlasts the gap
          if ((break_inc > cfg_i.packet_gap) && packet_active_q) begin
            packet_active_d = 1'b0;
            priority if (pip_q == 8'd1) begin
              if (pulse_win_q < cfg_i.start_short_below) begin
                bump[TallyShortStart] = 1'b1;
              end else if (pulse_win_q > cfg_i.start_long_above) begin
                bump[TallyLongStart] = 1'b1;
              end else if (test_pending_q) begin
                test_pending_d   = 1'b0;
                fail_d           = 1'b0;
                bump[TallyPass]  = 1'b1;
              end
            end else if (pip_q == 8'd3) begin
              clog_d               = 1'b1;
              bump[TallyShortClog] = burst_short;
              bump[TallyLongClog]  = burst_long;
            end else if (pip_q == 8'd5) begin
              overheat_d           = 1'b1;
              bump[TallyShortOver] = burst_short;
              bump[TallyLongOver]  = burst_long;
            end else begin
              bump[TallyUnknown] = 1'b1;
            end
          end
          break_win_d = (break_inc > BreakLimit) ? BreakRewind : break_inc;
        end
      end
      KindTestStart: begin
        test_pending_d = 1'b1;
        test_elapsed_d = '0;
      end
      KindTick: begin
        if (test_pending_q) begin
          test_elapsed_d = elapsed_inc;
          if (elapsed_inc > cfg_i.test_timeout) begin
            fail_d         = 1'b1;
            test_pending_d = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_active_q  <= 1'b0;
      packet_active_q <= 1'b0;
      pip_q           <= '0;
      pulse_win_q     <= '0;
      break_win_q     <= '0;
      test_pending_q  <= 1'b0;
      test_elapsed_q  <= '0;
      fail_q          <= 1'b0;
      overheat_q      <= 1'b0;
      clog_q          <= 1'b0;
      tally_q         <= '0;
    end else if (step_i) begin
      pulse_active_q  <= pulse_active_d;
      packet_active_q <= packet_active_d;
      pip_q           <= pip_d;
      pulse_win_q     <= pulse_win_d;
      break_win_q     <= break_win_d;
      test_pending_q  <= test_pending_d;
      test_elapsed_q  <= test_elapsed_d;
      fail_q          <= fail_d;
      overheat_q      <= overheat_d;
      clog_q          <= clog_d;
      for (int i = 0; i < NumTallies; i++) begin
        tally_q[i] <= tally_q[i] + {{(CntW-1){1'b0}}, bump[i]};
      end
    end
  end

  // state only advances when the result slot is free or being drained, so it doubles as payload
  assign result_o.overheat       = overheat_q;
  assign result_o.clog           = clog_q;
  assign result_o.self_test_fail = fail_q;
  assign result_o.tallies        = tally_q;

endmodule

`default_nettype wire

>>> src/vent_pulse_packet_classifier_core.sv
// ----------------------------------------------------------------------------
// vent_pulse_packet_classifier_core
// Decodes windowed edge counts into pulse packets and keeps event tallies.
// ----------------------------------------------------------------------------
// Path: an accepted item waits in the input register, then the state/result
//   update registers the result; an undrained result stalls the held item.
// Throughput: one item per cycle while results are taken; the only loop is the state update.
// Reset: asynchronous, active low; clears all state, tallies and flags and
//   loads the register defaults. No clearing pass is needed.
`default_nettype none

module vent_pulse_packet_classifier_core
  import vpc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready,
  vpc_in_if.sink                in_i,
  vpc_out_if.source             out_o
);

  cfg_t    cfg;
  result_t result;
  item_t   item_q;
  logic    in_valid_q;
  logic    out_valid_q;
  logic    step;

  vpc_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // advance the held item when the result slot is empty or being drained
  assign step       = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.kind         <= in_i.kind;
      item_q.sample_count <= in_i.sample_count;
    end
  end

  vpc_tracker u_tracker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  assign out_o.valid                = out_valid_q;
  assign out_o.overheat             = result.overheat;
  assign out_o.clog                 = result.clog;
  assign out_o.self_test_fail       = result.self_test_fail;
  assign out_o.single_window_pulses = result.tallies[TallySingle];
  assign out_o.short_starts         = result.tallies[TallyShortStart];
  assign out_o.long_starts          = result.tallies[TallyLongStart];
  assign out_o.short_clogs          = result.tallies[TallyShortClog];
  assign out_o.long_clogs           = result.tallies[TallyLongClog];
  assign out_o.short_overheats      = result.tallies[TallyShortOver];
  assign out_o.long_overheats       = result.tallies[TallyLongOver];
  assign out_o.unknown_packets      = result.tallies[TallyUnknown];
  assign out_o.selftest_passes      = result.tallies[TallyPass];

endmodule

`default_nettype wire

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the pulse packet classifier against its own model of the block.
// Drives sample, self-test and tick items through the valid/ready channels
// and programs the registers over APB between phases. A scoreboard class
// predicts the flags and tallies for every accepted item and compares them
// field by field with the results. Phases vary the register settings and
// the idling on both channels. One phase holds the result side off for a
// long stretch. A final phase drives a packet past the pulse-count limit.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import vpc_pkg::*;

  localparam logic [1:0] KindUnused = 2'd3;
  localparam int HoldCycles = 300;

  class classifier_board;
    cfg_t            cfg;
    bit              pulse_on;
    bit              packet_open;
    bit              test_pending;
    bit              test_fail;
    bit              overheat;
    bit              clog;
    logic [PipW-1:0] pulse_count;
    logic [CntW-1:0] pulse_len;
    logic [CntW-1:0] break_len;
    logic [CntW-1:0] test_age;
    logic [CntW-1:0] tallies[NumTallies];
    result_t         reports_due[$];
    int              errors;
    string           tally_names[NumTallies] = '{
      "single_window_pulses", "short_starts", "long_starts", "short_clogs",
      "long_clogs", "short_overheats", "long_overheats", "unknown_packets",
      "selftest_passes"
    };

    function new();
      cfg.pulse_threshold   = ThresholdRst;
      cfg.packet_gap        = PacketGapRst;
      cfg.start_short_below = StartShortRst;
      cfg.start_long_above  = StartLongRst;
      cfg.burst_short_below = BurstShortRst;
      cfg.burst_long_above  = BurstLongRst;
      cfg.test_timeout      = TestTimeoutRst;
      pulse_on     = 1'b0;
      packet_open  = 1'b0;
      test_pending = 1'b0;
      test_fail    = 1'b0;
      overheat     = 1'b0;
      clog         = 1'b0;
      pulse_count  = '0;
      pulse_len    = '0;
      break_len    = '0;
      test_age     = '0;
      foreach (tallies[i]) tallies[i] = '0;
      errors = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [DataW-1:0] value);
      case (idx)
        RegThreshold:   cfg.pulse_threshold   = value[ThrW-1:0];
        RegPacketGap:   cfg.packet_gap        = value[CntW-1:0];
        RegStartShort:  cfg.start_short_below = value[CntW-1:0];
        RegStartLong:   cfg.start_long_above  = value[CntW-1:0];
        RegBurstShort:  cfg.burst_short_below = value[CntW-1:0];
        RegBurstLong:   cfg.burst_long_above  = value[CntW-1:0];
        RegTestTimeout: cfg.test_timeout      = value[CntW-1:0];
        default: ;
      endcase
    endfunction

    // Tally the last pulse of a clog or overheat packet by its length
    function void tally_burst(int unsigned short_slot, int unsigned long_slot);
      if (pulse_len < cfg.burst_short_below) begin
        tallies[short_slot]++;
      end else if (pulse_len > cfg.burst_long_above) begin
        tallies[long_slot]++;
      end
    endfunction

    function void note_item(logic [1:0] kind, logic [ThrW-1:0] count);
      result_t r;
      case (kind)
        KindSample: begin
          if (count > cfg.pulse_threshold) begin
            if (!pulse_on) begin
              if (!packet_open) begin
                packet_open = 1'b1;
                pulse_count = 8'd1;
              end else if (pulse_count != PipMax) begin
                pulse_count++;
              end
              pulse_on  = 1'b1;
              pulse_len = '0;
            end
            if (pulse_len != CntMax) pulse_len++;
          end else begin
            if (pulse_on) begin
              if (pulse_len == 16'd1) tallies[TallySingle]++;
              pulse_on  = 1'b0;
              break_len = '0;
            end
            break_len++;
            if (break_len > cfg.packet_gap && packet_open) begin
              if (pulse_count == 8'd1) begin
                if (pulse_len < cfg.start_short_below) begin
                  tallies[TallyShortStart]++;
                end else if (pulse_len > cfg.start_long_above) begin
                  tallies[TallyLongStart]++;
                end else if (test_pending) begin
                  test_pending = 1'b0;
                  test_fail    = 1'b0;
                  tallies[TallyPass]++;
                end
              end else if (pulse_count == 8'd3) begin
                tally_burst(TallyShortClog, TallyLongClog);
                clog = 1'b1;
              end else if (pulse_count == 8'd5) begin
                tally_burst(TallyShortOver, TallyLongOver);
                overheat = 1'b1;
              end else begin
                tallies[TallyUnknown]++;
              end
              packet_open = 1'b0;
            end
            // rewind a break that has run far past any packet
            if (break_len > BreakLimit) break_len = BreakRewind;
          end
        end
        KindTestStart: begin
          test_pending = 1'b1;
          test_age     = '0;
        end
        KindTick: begin
          if (test_pending) begin
            if (test_age != CntMax) test_age++;
            if (test_age > cfg.test_timeout) begin
              test_fail    = 1'b1;
              test_pending = 1'b0;
            end
          end
        end
        default: ;
      endcase
      r.overheat       = overheat;
      r.clog           = clog;
      r.self_test_fail = test_fail;
      foreach (tallies[i]) r.tallies[i] = tallies[i];
      reports_due.push_back(r);
    endfunction

    function void check_report(result_t got);
      result_t want;
      int      i;
      if (reports_due.size() == 0) begin
        $error("result arrived with no item pending");
        errors++;
        return;
      end
      want = reports_due.pop_front();
      if (got.overheat !== want.overheat) begin
        $error("overheat: expected %0d, got %0d", want.overheat, got.overheat);
        errors++;
      end
      if (got.clog !== want.clog) begin
        $error("clog: expected %0d, got %0d", want.clog, got.clog);
        errors++;
      end
      if (got.self_test_fail !== want.self_test_fail) begin
        $error("self_test_fail: expected %0d, got %0d", want.self_test_fail,
               got.self_test_fail);
        errors++;
      end
      for (i = 0; i < NumTallies; i++) begin
        if (got.tallies[i] !== want.tallies[i]) begin
          $error("%s: expected %0d, got %0d", tally_names[i], want.tallies[i],
                 got.tallies[i]);
          errors++;
        end
      end
    endfunction
  endclass

  logic             clk_i   = 1'b0;
  logic             rst_ni  = 1'b0;
  logic             psel    = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite  = 1'b0;
  logic [AddrW-1:0] paddr   = '0;
  logic [DataW-1:0] pwdata  = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  vpc_in_if  in_ch();
  vpc_out_if out_ch();

  vent_pulse_packet_classifier_core uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_ch),
    .out_o   (out_ch)
  );

  classifier_board board;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int holds_asked    = 0;
  int items_sent     = 0;

  always #2 clk_i = ~clk_i;

  // Result side: random stalls, plus a long hold-off on request
  initial begin : receiver
    int hold_left;
    int holds_seen;
    hold_left  = 0;
    holds_seen = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (holds_asked != holds_seen) begin
        holds_seen = holds_asked;
        hold_left  = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        board.note_item(in_ch.kind, in_ch.sample_count);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.overheat                 = out_ch.overheat;
        got.clog                     = out_ch.clog;
        got.self_test_fail           = out_ch.self_test_fail;
        got.tallies[TallySingle]     = out_ch.single_window_pulses;
        got.tallies[TallyShortStart] = out_ch.short_starts;
        got.tallies[TallyLongStart]  = out_ch.long_starts;
        got.tallies[TallyShortClog]  = out_ch.short_clogs;
        got.tallies[TallyLongClog]   = out_ch.long_clogs;
        got.tallies[TallyShortOver]  = out_ch.short_overheats;
        got.tallies[TallyLongOver]   = out_ch.long_overheats;
        got.tallies[TallyUnknown]    = out_ch.unknown_packets;
        got.tallies[TallyPass]       = out_ch.selftest_passes;
        board.check_report(got);
      end
    end
  end

  task automatic send_item(logic [1:0] kind, logic [ThrW-1:0] count);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= kind;
    in_ch.sample_count <= count;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
  endtask

  // Drop valid and wait until every result has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (board.reports_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [DataW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    board.set_reg(idx, value);
  endtask

  // Write all registers; bits above each register's width carry junk
  task automatic set_config(int unsigned thr, int unsigned gap, int unsigned ss,
                            int unsigned sl, int unsigned bs, int unsigned bl,
                            int unsigned timeout);
    logic [DataW-1:0] junk;
    drain();
    junk = $urandom & 32'hFFFF_0000;
    write_reg(RegThreshold, thr | junk | ($urandom_range(1) << 15));
    write_reg(RegPacketGap, gap | junk);
    write_reg(RegStartShort, ss | junk);
    write_reg(RegStartLong, sl | junk);
    write_reg(RegBurstShort, bs | junk);
    write_reg(RegBurstLong, bl | junk);
    write_reg(RegTestTimeout, timeout | junk);
  endtask

  function automatic logic [ThrW-1:0] pulse_count_value();
    int unsigned thr;
    thr = board.cfg.pulse_threshold;
    if (thr == 32767) return $urandom_range(32767, 0);
    if ($urandom_range(1)) return $urandom_range(32767, thr + 1);
    return $urandom_range((thr + 60 > 32767) ? 32767 : thr + 60, thr + 1);
  endfunction

  function automatic logic [ThrW-1:0] break_count_value();
    int unsigned thr;
    thr = board.cfg.pulse_threshold;
    if ($urandom_range(1)) return $urandom_range(thr, 0);
    return $urandom_range(thr, (thr > 20) ? thr - 20 : 0);
  endfunction

  // A packet of the given pulse count with random lengths, then a break past the gap, capped at 20
  task automatic send_packet(int pulses);
    int unsigned gap;
    int unsigned len_max;
    int unsigned len;
    int unsigned close_len;
    gap = board.cfg.packet_gap;
    len_max = (pulses == 1) ? board.cfg.start_long_above + 3 : board.cfg.burst_long_above + 3;
    if (len_max > 40) len_max = 40;
    for (int p = 0; p < pulses; p++) begin
      len = $urandom_range(len_max, 1);
      repeat (len) send_item(KindSample, pulse_count_value());
      if (p < pulses - 1) begin
        repeat ((gap == 0) ? 1 : $urandom_range(gap > 12 ? 12 : gap, 1)) begin
          send_item(KindSample, break_count_value());
        end
      end
    end
    close_len = gap + 1 + $urandom_range(2);
    if (close_len > 20) close_len = 20;
    repeat (close_len) send_item(KindSample, break_count_value());
  endtask

  task automatic run_random(int n_items);
    int target;
    int pick;
    int unsigned ticks;
    int pulse_mix[13] = '{1, 1, 1, 3, 3, 3, 5, 5, 5, 2, 4, 7, 0};
    target = items_sent + n_items;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 68) begin
        send_packet(pulse_mix[$urandom_range(12)]);
      end else if (pick < 80) begin
        send_item(KindTestStart, $urandom_range(32767));
      end else if (pick < 94) begin
        ticks = board.cfg.test_timeout + 2;
        if (ticks > 40) ticks = 40;
        repeat ($urandom_range(ticks, 1)) send_item(KindTick, $urandom_range(32767));
      end else begin
        repeat ($urandom_range(4, 1)) begin
          send_item($urandom_range(3), $urandom_range(32767));
        end
      end
    end
  endtask

  task automatic random_config();
    int unsigned ss;
    int unsigned bs;
    ss = $urandom_range(10);
    bs = $urandom_range(6);
    set_config($urandom_range(3) == 0 ? $urandom_range(32767) : $urandom_range(40),
               $urandom_range(8), ss, ss + $urandom_range(10), bs,
               bs + $urandom_range(6), $urandom_range(12));
  endtask

  initial begin
    board = new();
    in_ch.valid        = 1'b0;
    in_ch.kind         = KindSample;
    in_ch.sample_count = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes and each item kind under the reset settings
    send_item(KindSample, 15'd0);
    send_item(KindSample, 15'h7FFF);
    send_item(KindSample, 15'd5);
    send_item(KindTestStart, 15'd0);
    send_item(KindTick, 15'h7FFF);
    send_item(KindUnused, 15'h2AAA);

    set_config(5, 1, 2, 3, 2, 3, 1);
    // mid-length single pulse confirms a pending self test
    send_item(KindTestStart, 15'd0);
    repeat (2) send_item(KindSample, 15'd6);
    repeat (2) send_item(KindSample, 15'd0);
    // self test runs out of ticks
    send_item(KindTestStart, 15'd0);
    repeat (2) send_item(KindTick, 15'd0);
    // three one-window pulses: clog with a short last pulse
    repeat (3) begin
      send_item(KindSample, 15'd100);
      send_item(KindSample, 15'd1);
    end
    send_item(KindSample, 15'd1);

    // Random phases under the four idling mixes
    random_config();
    holds_asked++;
    run_random(200);

    random_config();
    send_idle_pct = 48;
    run_random(200);

    random_config();
    send_idle_pct  = 0;
    recv_stall_pct = 48;
    run_random(200);

    random_config();
    send_idle_pct  = 22;
    recv_stall_pct = 22;
    run_random(200);

    // Register extremes
    set_config(0, 0, 0, 0, 0, 0, 0);
    run_random(100);
    set_config(0, 0, 65535, 65535, 65535, 65535, 65535);
    run_random(100);
    set_config(32767, 65535, 65535, 65535, 65535, 65535, 65535);
    run_random(50);

    // Saturation: pulses per packet
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_config(0, 1, 2, 65534, 0, 65535, 65535);
    repeat (257) begin
      send_item(KindSample, 15'd1);
      send_item(KindSample, 15'd0);
    end
    send_item(KindSample, 15'd0);

    drain();
    repeat (10) @(posedge clk_i);
    if (board.errors == 0 && board.reports_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #(3_000_000);
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
